FILE: rtl/button_gesture_classifier_unit_macros.svh
// assertion macros for the button gesture classifier
`ifndef BUTTON_GESTURE_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define BGC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bgc assertion failed");
// antecedent in this cycle implies consequent in the next
`define BGC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bgc assertion failed");
`else
`define BGC_ASSERT(name, prop)
`define BGC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/bgc_pkg.sv
// types, codes and constants of the button gesture classifier
package bgc_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned CODE_W = 4;

  // output buffer geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_W-1:0] SHORT_RST     = 16'd500;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] LONG_LONG_RST = 16'd3000;
  localparam logic [CFG_W-1:0] DOUBLE_RST    = 16'd300;

  typedef enum logic [CODE_W-1:0] {
    EV_CLICK      = 4'd0,
    EV_DOUBLE     = 4'd1,
    EV_SHORT      = 4'd2,
    EV_LONG       = 4'd3,
    EV_LLONG      = 4'd4,
    EV_REL        = 4'd5,
    EV_SHORT_REL  = 4'd6,
    EV_LONG_REL   = 4'd7,
    EV_LLONG_REL  = 4'd8,
    EV_DOUBLE_REL = 4'd9,
    EV_ERROR      = 4'd10
  } evt_code_e;

  typedef enum logic [IDX_W-1:0] {
    REG_CLICK_LEVEL     = 3'd0,
    REG_DEBOUNCE_TICKS  = 3'd1,
    REG_SHORT_TICKS     = 3'd2,
    REG_LONG_TICKS      = 3'd3,
    REG_LONG_LONG_TICKS = 3'd4,
    REG_DOUBLE_TICKS    = 3'd5,
    REG_BUTTON_ID       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    evt_code_e       code;
    logic [ID_W-1:0] id;
    logic            last;
  } res_t;

  // release word that closes a gesture
  function automatic evt_code_e release_code(input evt_code_e g);
    evt_code_e r;
    case (g)
      EV_CLICK:  r = EV_REL;
      EV_SHORT:  r = EV_SHORT_REL;
      EV_LONG:   r = EV_LONG_REL;
      EV_LLONG:  r = EV_LLONG_REL;
      EV_DOUBLE: r = EV_DOUBLE_REL;
      default:   r = EV_ERROR;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/button_gesture_classifier_unit.sv
// Output: the events of an accepted tick are registered into the output buffer, behind any older words.
// Throughput: one tick per cycle while ticks give at most one event and the output keeps up;
//   the output moves one word per cycle while out_ready_i is high, and a tick can give two words.
// A four-entry output buffer decouples the sides; input ready needs room for two words.
// Reset: timers, flags and buffer cleared, registers back to their defaults; no clearing pass.
// button gesture classifier top level: debounce, gesture timers and event buffer
`include "button_gesture_classifier_unit_macros.svh"

module button_gesture_classifier_unit #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [bgc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [bgc_pkg::CFG_W-1:0]   cfg_wdata_i,
  // pin samples
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        pin_level_i,
  // events
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bgc_pkg::CODE_W-1:0]  event_code_o,
  output logic [bgc_pkg::ID_W-1:0]    source_id_o,
  output logic                        last_of_tick_o
);

  localparam logic [32:0] TMAX_EXT = (33'd1 << TIMER_BITS) - 33'd1;
  localparam logic [TIMER_BITS-1:0] ONE_T = TIMER_BITS'(1);

  // saturate a register value to the timer width
  function automatic logic [TIMER_BITS-1:0] load_t(input logic [bgc_pkg::CFG_W-1:0] v);
    logic [TIMER_BITS-1:0] r;
    if (33'(v) > TMAX_EXT) begin
      r = '1;
    end else begin
      r = TIMER_BITS'(33'(v));
    end
    return r;
  endfunction

  // configuration registers
  logic                      click_level_q;
  logic [bgc_pkg::CFG_W-1:0] debounce_ticks_q, short_ticks_q, long_ticks_q;
  logic [bgc_pkg::CFG_W-1:0] long_long_ticks_q, double_ticks_q;
  logic [bgc_pkg::ID_W-1:0]  button_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_level_q     <= 1'b0;
      debounce_ticks_q  <= bgc_pkg::DEBOUNCE_RST;
      short_ticks_q     <= bgc_pkg::SHORT_RST;
      long_ticks_q      <= bgc_pkg::LONG_RST;
      long_long_ticks_q <= bgc_pkg::LONG_LONG_RST;
      double_ticks_q    <= bgc_pkg::DOUBLE_RST;
      button_id_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bgc_pkg::REG_CLICK_LEVEL:     click_level_q     <= cfg_wdata_i[0];
        bgc_pkg::REG_DEBOUNCE_TICKS:  debounce_ticks_q  <= cfg_wdata_i;
        bgc_pkg::REG_SHORT_TICKS:     short_ticks_q     <= cfg_wdata_i;
        bgc_pkg::REG_LONG_TICKS:      long_ticks_q      <= cfg_wdata_i;
        bgc_pkg::REG_LONG_LONG_TICKS: long_long_ticks_q <= cfg_wdata_i;
        bgc_pkg::REG_DOUBLE_TICKS:    double_ticks_q    <= cfg_wdata_i;
        bgc_pkg::REG_BUTTON_ID:       button_id_q       <= cfg_wdata_i[bgc_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  // classifier state
  logic primed_q, primed_d, stable_q, stable_d, press_q, press_d;
  logic deb_busy_q, deb_busy_d, hold_busy_q, hold_busy_d, win_busy_q, win_busy_d;
  logic [TIMER_BITS-1:0] deb_cnt_q, deb_cnt_d, hold_cnt_q, hold_cnt_d;
  logic [TIMER_BITS-1:0] win_cnt_q, win_cnt_d, since_q, since_d;
  bgc_pkg::evt_code_e    gest_q, gest_d;

  logic in_fire, pop;
  logic [3:0]         cand_vld;
  bgc_pkg::evt_code_e cand_code [4];

  assign in_fire = in_valid_i & in_ready_o;

  // one tick of the classifier, candidates in emission order
  always_comb begin
    logic win_exp, hold_exp, deb_exp;
    primed_d   = primed_q;
    stable_d   = stable_q;
    press_d    = press_q;
    deb_busy_d = deb_busy_q;
    deb_cnt_d  = deb_cnt_q;
    hold_busy_d = hold_busy_q;
    hold_cnt_d = hold_cnt_q;
    win_busy_d = win_busy_q;
    win_cnt_d  = win_cnt_q;
    since_d    = since_q;
    gest_d     = gest_q;
    cand_vld   = '0;
    for (int i = 0; i < 4; i++) begin
      cand_code[i] = bgc_pkg::EV_ERROR;
    end
    win_exp  = 1'b0;
    hold_exp = 1'b0;
    deb_exp  = 1'b0;
    if (in_fire) begin
      if (!primed_q) begin
        primed_d = 1'b1;
        stable_d = pin_level_i;
      end else begin
        if (since_q != '1) begin
          since_d = since_q + ONE_T;
        end
        // release window
        if (win_busy_q) begin
          if (win_cnt_q <= ONE_T) begin
            win_exp    = 1'b1;
            win_busy_d = 1'b0;
            win_cnt_d  = '0;
          end else begin
            win_cnt_d = win_cnt_q - ONE_T;
          end
        end
        if (win_exp) begin
          gest_d       = bgc_pkg::EV_REL;
          cand_vld[0]  = 1'b1;
          cand_code[0] = bgc_pkg::EV_REL;
        end
        // hold timer
        if (hold_busy_q) begin
          if (hold_cnt_q <= ONE_T) begin
            hold_exp    = 1'b1;
            hold_busy_d = 1'b0;
            hold_cnt_d  = '0;
          end else begin
            hold_cnt_d = hold_cnt_q - ONE_T;
          end
        end
        if (hold_exp) begin
          case (gest_d)
            bgc_pkg::EV_CLICK: begin
              gest_d = bgc_pkg::EV_SHORT;
              cand_vld[1] = 1'b1;
              cand_code[1] = bgc_pkg::EV_SHORT;
              hold_busy_d = 1'b1;
              hold_cnt_d = load_t(long_ticks_q);
            end
            bgc_pkg::EV_SHORT: begin
              gest_d = bgc_pkg::EV_LONG;
              cand_vld[1] = 1'b1;
              cand_code[1] = bgc_pkg::EV_LONG;
              hold_busy_d = 1'b1;
              hold_cnt_d = load_t(long_long_ticks_q);
            end
            bgc_pkg::EV_LONG: begin
              gest_d = bgc_pkg::EV_LLONG;
              cand_vld[1] = 1'b1;
              cand_code[1] = bgc_pkg::EV_LLONG;
            end
            default: ;
          endcase
        end
        // debounce timer
        if (deb_busy_q) begin
          if (deb_cnt_q <= ONE_T) begin
            deb_exp    = 1'b1;
            deb_busy_d = 1'b0;
            deb_cnt_d  = '0;
          end else begin
            deb_cnt_d = deb_cnt_q - ONE_T;
          end
        end
        if (deb_exp) begin
          if (pin_level_i != stable_q) begin
            cand_vld[2]  = 1'b1;
            cand_code[2] = bgc_pkg::EV_ERROR;
          end else if (press_q) begin
            if (33'(since_d) < 33'(double_ticks_q)) begin
              gest_d = bgc_pkg::EV_DOUBLE;
              cand_vld[2] = 1'b1;
              cand_code[2] = bgc_pkg::EV_DOUBLE;
              win_busy_d = 1'b0;
              win_cnt_d = '0;
            end else begin
              if (win_busy_d) begin
                cand_vld[2] = 1'b1;
                cand_code[2] = bgc_pkg::EV_REL;
                win_busy_d = 1'b0;
                win_cnt_d = '0;
              end
              gest_d = bgc_pkg::EV_CLICK;
              cand_vld[3] = 1'b1;
              cand_code[3] = bgc_pkg::EV_CLICK;
              hold_busy_d = 1'b1;
              hold_cnt_d = load_t(short_ticks_q);
            end
            since_d = '0;
          end else begin
            hold_busy_d = 1'b0;
            hold_cnt_d  = '0;
            if (gest_d == bgc_pkg::EV_CLICK) begin
              win_busy_d = 1'b1;
              win_cnt_d  = load_t(double_ticks_q);
            end else begin
              gest_d = bgc_pkg::release_code(gest_d);
              cand_vld[2] = 1'b1;
              cand_code[2] = gest_d;
            end
          end
        end
        // level change starts a debounce
        if (!deb_busy_d && (pin_level_i != stable_q)) begin
          stable_d   = pin_level_i;
          press_d    = (pin_level_i == click_level_q);
          deb_busy_d = 1'b1;
          deb_cnt_d  = load_t(debounce_ticks_q);
        end
      end
    end
  end

  // keep the first two candidates
  logic [1:0]         n_res;
  bgc_pkg::evt_code_e ev0, ev1;
  bgc_pkg::res_t      res0, res1;

  always_comb begin
    n_res = 2'd0;
    ev0   = bgc_pkg::EV_ERROR;
    ev1   = bgc_pkg::EV_ERROR;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i]) begin
        if (n_res == 2'd0) begin
          ev0   = cand_code[i];
          n_res = 2'd1;
        end else if (n_res == 2'd1) begin
          ev1   = cand_code[i];
          n_res = 2'd2;
        end
      end
    end
  end

  assign res0 = '{code: ev0, id: button_id_q, last: (n_res == 2'd1)};
  assign res1 = '{code: ev1, id: button_id_q, last: 1'b1};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      stable_q    <= 1'b0;
      press_q     <= 1'b0;
      deb_busy_q  <= 1'b0;
      deb_cnt_q   <= '0;
      hold_busy_q <= 1'b0;
      hold_cnt_q  <= '0;
      win_busy_q  <= 1'b0;
      win_cnt_q   <= '0;
      since_q     <= '1;
      gest_q      <= bgc_pkg::EV_REL;
    end else begin
      primed_q    <= primed_d;
      stable_q    <= stable_d;
      press_q     <= press_d;
      deb_busy_q  <= deb_busy_d;
      deb_cnt_q   <= deb_cnt_d;
      hold_busy_q <= hold_busy_d;
      hold_cnt_q  <= hold_cnt_d;
      win_busy_q  <= win_busy_d;
      win_cnt_q   <= win_cnt_d;
      since_q     <= since_d;
      gest_q      <= gest_d;
    end
  end

  // output word buffer
  bgc_pkg::res_t                fifo_q [bgc_pkg::FIFO_DEPTH];
  logic [bgc_pkg::PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [bgc_pkg::CNT_W-1:0]    count_q, count_d;

  assign wr_ptr_nx   = wr_ptr_q + bgc_pkg::PTR_W'(1);
  assign pop         = out_valid_o & out_ready_i;
  assign in_ready_o  = (count_q <= bgc_pkg::CNT_W'(bgc_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_d    = wr_ptr_q + bgc_pkg::PTR_W'(n_res);
  assign rd_ptr_d    = rd_ptr_q + bgc_pkg::PTR_W'(pop);
  assign count_d     = count_q + bgc_pkg::CNT_W'(n_res) - bgc_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < bgc_pkg::FIFO_DEPTH; i++) begin
      if ((n_res != 2'd0) && (bgc_pkg::PTR_W'(i) == wr_ptr_q)) begin
        fifo_q[i] <= res0;
      end else if ((n_res == 2'd2) && (bgc_pkg::PTR_W'(i) == wr_ptr_nx)) begin
        fifo_q[i] <= res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign event_code_o   = fifo_q[rd_ptr_q].code;
  assign source_id_o    = fifo_q[rd_ptr_q].id;
  assign last_of_tick_o = fifo_q[rd_ptr_q].last;

  // checks
  `BGC_ASSERT(a_fifo_bound, count_q <= bgc_pkg::CNT_W'(bgc_pkg::FIFO_DEPTH))
  `BGC_ASSERT_NEXT(a_fifo_count, 1'b1, count_q == $past(count_d))
  `BGC_ASSERT(a_prime_silent, !primed_q |-> (n_res == 2'd0))
  `BGC_ASSERT(a_deb_idle_zero, !deb_busy_q |-> (deb_cnt_q == '0))
  `BGC_ASSERT(a_hold_idle_zero, !hold_busy_q |-> (hold_cnt_q == '0))

endmodule

FILE: tb/tb.sv
// testbench for the button gesture classifier: scripted and random ticks against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TMR_W = 16;
  localparam logic [bgc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned HOLD_CAP = 60;
  localparam int unsigned GAP_CAP  = 40;

  // one register setting per phase, with the number of random ticks to run under it
  typedef struct packed {
    logic        click;
    logic [15:0] deb;
    logic [15:0] sh;
    logic [15:0] lg;
    logic [15:0] ll;
    logic [15:0] dbl;
    logic [7:0]  id;
    logic        poke_unused;
    logic [15:0] budget;
  } setting_t;

  // scripted tick: pin level, and a typed expectation where it is obvious
  typedef struct packed {
    logic               pin;
    logic               typed;
    logic [1:0]         n_typed;
    bgc_pkg::evt_code_e code;
  } script_row_t;

  localparam setting_t SCRIPT_SETTING =
    '{1'b1, 16'd1, 16'd4, 16'd1, 16'd1, 16'd5, 8'hA5, 1'b0, 16'd0};

  localparam setting_t PHASES [5] = '{
    '{1'b0, 16'd1,     16'd4,     16'd3,     16'd5,     16'd6,     8'h5A, 1'b0, 16'd700},
    '{1'b1, 16'd3,     16'd8,     16'd6,     16'd10,    16'd15,    8'hFF, 1'b1, 16'd700},
    '{1'b0, 16'd1,     16'd1,     16'd1,     16'd1,     16'd1,     8'h00, 1'b0, 16'd350},
    '{1'b1, 16'd2,     16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'h3C, 1'b1, 16'd200},
    '{1'b0, 16'd65535, 16'd20,    16'd20,    16'd20,    16'd20,    8'hC3, 1'b0, 16'd50}
  };

  // priming, bounce errors, full hold ladder, click release window, double click
  localparam script_row_t SCRIPT [27] = '{
    '{1'b0, 1'b1, 2'd0, bgc_pkg::EV_CLICK},   // first tick only primes the level
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b1, 2'd1, bgc_pkg::EV_ERROR},   // bounce inside debounce
    '{1'b0, 1'b1, 2'd1, bgc_pkg::EV_ERROR},   // release with no gesture open
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},   // new click while release window runs
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b1, 1'b0, 2'd0, bgc_pkg::EV_CLICK},   // second press inside the window
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK},
    '{1'b0, 1'b0, 2'd0, bgc_pkg::EV_CLICK}
  };

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [bgc_pkg::IDX_W-1:0]  cfg_idx_i   = '0;
  logic [bgc_pkg::CFG_W-1:0]  cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic                       pin_level_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [bgc_pkg::CODE_W-1:0] event_code_o;
  logic [bgc_pkg::ID_W-1:0]   source_id_o;
  logic                       last_of_tick_o;

  button_gesture_classifier_unit #(
    .TIMER_BITS(TMR_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pin_level_i   (pin_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_code_o  (event_code_o),
    .source_id_o   (source_id_o),
    .last_of_tick_o(last_of_tick_o)
  );

  always #1 clk_i = ~clk_i;

  // register mirror
  logic                     click_lvl = 1'b0;
  logic [TMR_W-1:0]         deb_t     = bgc_pkg::DEBOUNCE_RST;
  logic [TMR_W-1:0]         short_t   = bgc_pkg::SHORT_RST;
  logic [TMR_W-1:0]         long_t    = bgc_pkg::LONG_RST;
  logic [TMR_W-1:0]         llong_t   = bgc_pkg::LONG_LONG_RST;
  logic [TMR_W-1:0]         dbl_t     = bgc_pkg::DOUBLE_RST;
  logic [bgc_pkg::ID_W-1:0] bid       = '0;

  // classifier state as predicted
  logic               primed      = 1'b0;
  logic               stable_lvl  = 1'b0;
  logic               press_flag  = 1'b0;
  logic               deb_busy    = 1'b0;
  logic               hold_busy   = 1'b0;
  logic               win_busy    = 1'b0;
  logic [TMR_W-1:0]   deb_cnt     = '0;
  logic [TMR_W-1:0]   hold_cnt    = '0;
  logic [TMR_W-1:0]   win_cnt     = '0;
  logic [TMR_W-1:0]   since_press = '1;
  bgc_pkg::evt_code_e gesture     = bgc_pkg::EV_REL;

  bgc_pkg::res_t tick_events [$];
  bgc_pkg::res_t pending_events [$];
  int unsigned   failures      = 0;
  int unsigned   ticks_sent    = 0;
  int unsigned   in_idle_pct   = 31;
  int unsigned   out_stall_pct = 52;

  // counts a running timer down, true on the tick it runs out
  function automatic logic timer_done(inout logic busy, inout logic [TMR_W-1:0] cnt);
    if (!busy) return 1'b0;
    if (cnt <= TMR_W'(1)) begin
      busy = 1'b0;
      cnt  = '0;
      return 1'b1;
    end
    cnt = cnt - TMR_W'(1);
    return 1'b0;
  endfunction

  // release word that ends the open gesture
  function automatic bgc_pkg::evt_code_e closing_event(input bgc_pkg::evt_code_e g);
    case (g)
      bgc_pkg::EV_CLICK:  return bgc_pkg::EV_REL;
      bgc_pkg::EV_SHORT:  return bgc_pkg::EV_SHORT_REL;
      bgc_pkg::EV_LONG:   return bgc_pkg::EV_LONG_REL;
      bgc_pkg::EV_LLONG:  return bgc_pkg::EV_LLONG_REL;
      bgc_pkg::EV_DOUBLE: return bgc_pkg::EV_DOUBLE_REL;
      default:            return bgc_pkg::EV_ERROR;
    endcase
  endfunction

  // at most two words per tick
  function automatic void post_event(input bgc_pkg::evt_code_e c);
    bgc_pkg::res_t r;
    if (tick_events.size() < 2) begin
      r.code = c;
      r.id   = bid;
      r.last = 1'b0;
      tick_events.push_back(r);
    end
  endfunction

  // one pin tick through the classifier: fills tick_events
  function automatic void classify_tick(input logic pin);
    tick_events.delete();
    if (!primed) begin
      primed     = 1'b1;
      stable_lvl = pin;
      return;
    end
    if (since_press != '1) since_press = since_press + TMR_W'(1);

    // release window ran out
    if (timer_done(win_busy, win_cnt)) begin
      gesture = bgc_pkg::EV_REL;
      post_event(bgc_pkg::EV_REL);
    end

    // hold ladder: short, long, long-long; silent in any other gesture
    if (timer_done(hold_busy, hold_cnt)) begin
      case (gesture)
        bgc_pkg::EV_CLICK: begin
          gesture = bgc_pkg::EV_SHORT;
          post_event(bgc_pkg::EV_SHORT);
          hold_busy = 1'b1;
          hold_cnt  = long_t;
        end
        bgc_pkg::EV_SHORT: begin
          gesture = bgc_pkg::EV_LONG;
          post_event(bgc_pkg::EV_LONG);
          hold_busy = 1'b1;
          hold_cnt  = llong_t;
        end
        bgc_pkg::EV_LONG: begin
          gesture = bgc_pkg::EV_LLONG;
          post_event(bgc_pkg::EV_LLONG);
        end
        default: ;
      endcase
    end

    // debounce ran out: confirm the level or flag a bounce
    if (timer_done(deb_busy, deb_cnt)) begin
      if (pin != stable_lvl) begin
        post_event(bgc_pkg::EV_ERROR);
      end else if (press_flag) begin
        if (since_press < dbl_t) begin
          gesture = bgc_pkg::EV_DOUBLE;
          post_event(bgc_pkg::EV_DOUBLE);
          win_busy = 1'b0;
          win_cnt  = '0;
        end else begin
          if (win_busy) begin
            gesture = bgc_pkg::EV_REL;
            post_event(bgc_pkg::EV_REL);
            win_busy = 1'b0;
            win_cnt  = '0;
          end
          gesture = bgc_pkg::EV_CLICK;
          post_event(bgc_pkg::EV_CLICK);
          hold_busy = 1'b1;
          hold_cnt  = short_t;
        end
        since_press = '0;
      end else begin
        hold_busy = 1'b0;
        hold_cnt  = '0;
        if (gesture == bgc_pkg::EV_CLICK) begin
          win_busy = 1'b1;
          win_cnt  = dbl_t;
        end else begin
          gesture = closing_event(gesture);
          post_event(gesture);
        end
      end
    end

    // a level change starts a debounce
    if (!deb_busy && pin != stable_lvl) begin
      stable_lvl = pin;
      press_flag = (pin == click_lvl);
      deb_busy   = 1'b1;
      deb_cnt    = deb_t;
    end
  endfunction

  // send one pin tick and queue what it should produce
  task automatic send_tick(input logic pin, input logic typed, input logic [1:0] n_typed,
                           input bgc_pkg::evt_code_e code);
    bgc_pkg::res_t r;
    int unsigned   i;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
    classify_tick(pin);
    if (typed) begin
      if (n_typed != 0) begin
        r.code = code;
        r.id   = bid;
        r.last = 1'b1;
        pending_events.push_back(r);
      end
    end else begin
      for (i = 0; i < tick_events.size(); i++) begin
        r      = tick_events[i];
        r.last = (i + 1 == tick_events.size());
        pending_events.push_back(r);
      end
    end
    // idle pattern: sender-heavy, then receiver-heavy, then none
    if (ticks_sent < 800) begin
      in_idle_pct   = 31;
      out_stall_pct = 52;
    end else if (ticks_sent < 1600) begin
      in_idle_pct   = 52;
      out_stall_pct = 31;
    end else begin
      in_idle_pct   = 0;
      out_stall_pct = 0;
    end
  endtask

  task automatic send_run(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl, 1'b0, 2'd0, bgc_pkg::EV_CLICK);
  endtask

  // short pulses around an edge, sometimes
  task automatic maybe_bounce(input logic lvl);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_run(lvl, 1);
        send_run(!lvl, $urandom_range(1, 2));
      end
    end
  endtask

  // press/release gestures with random lengths, some bounces and some noise
  task automatic run_gestures(input int unsigned budget);
    int unsigned start;
    int unsigned hold_span;
    int unsigned gap_span;
    start     = ticks_sent;
    hold_span = deb_t + short_t + long_t + llong_t + 3;
    gap_span  = dbl_t + deb_t + 4;
    if (hold_span > HOLD_CAP) hold_span = HOLD_CAP;
    if (gap_span > GAP_CAP) gap_span = GAP_CAP;
    while (ticks_sent - start < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) send_run(1'($urandom_range(0, 1)), 1);
      end else begin
        maybe_bounce(click_lvl);
        send_run(click_lvl, $urandom_range(1, hold_span));
        maybe_bounce(!click_lvl);
        send_run(!click_lvl, $urandom_range(1, gap_span));
      end
    end
  endtask

  // wait for every expected word, then let ticks with no word drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bgc_pkg::IDX_W-1:0] idx,
                           input logic [bgc_pkg::CFG_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (idx)
      bgc_pkg::REG_CLICK_LEVEL:     click_lvl = d[0];
      bgc_pkg::REG_DEBOUNCE_TICKS:  deb_t     = d;
      bgc_pkg::REG_SHORT_TICKS:     short_t   = d;
      bgc_pkg::REG_LONG_TICKS:      long_t    = d;
      bgc_pkg::REG_LONG_LONG_TICKS: llong_t   = d;
      bgc_pkg::REG_DOUBLE_TICKS:    dbl_t     = d;
      bgc_pkg::REG_BUTTON_ID:       bid       = d[bgc_pkg::ID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input setting_t s);
    write_reg(bgc_pkg::REG_CLICK_LEVEL, {15'd0, s.click});
    write_reg(bgc_pkg::REG_DEBOUNCE_TICKS, s.deb);
    write_reg(bgc_pkg::REG_SHORT_TICKS, s.sh);
    write_reg(bgc_pkg::REG_LONG_TICKS, s.lg);
    write_reg(bgc_pkg::REG_LONG_LONG_TICKS, s.ll);
    write_reg(bgc_pkg::REG_DOUBLE_TICKS, s.dbl);
    write_reg(bgc_pkg::REG_BUTTON_ID, {8'd0, s.id});
    // out-of-range index must leave every register alone
    if (s.poke_unused) write_reg(REG_UNUSED, 16'hFFFF);
    cfg_we_i <= 1'b0;
  endtask

  // output side: random stalls, each accepted word checked against the oldest expectation
  always @(posedge clk_i) begin
    bgc_pkg::res_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected word: event_code %0d source_id %0d last_of_tick %0d",
               event_code_o, source_id_o, last_of_tick_o);
        failures++;
      end else begin
        exp_w = pending_events.pop_front();
        if (event_code_o !== exp_w.code) begin
          $error("event_code: expected %0d, got %0d", exp_w.code, event_code_o);
          failures++;
        end
        if (source_id_o !== exp_w.id) begin
          $error("source_id: expected %0d, got %0d", exp_w.id, source_id_o);
          failures++;
        end
        if (last_of_tick_o !== exp_w.last) begin
          $error("last_of_tick: expected %0d, got %0d", exp_w.last, last_of_tick_o);
          failures++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // main sequence
  initial begin : stimulus
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_setting(SCRIPT_SETTING);
    for (k = 0; k < $size(SCRIPT); k++) begin
      send_tick(SCRIPT[k].pin, SCRIPT[k].typed, SCRIPT[k].n_typed, SCRIPT[k].code);
    end
    for (k = 0; k < $size(PHASES); k++) begin
      settle();
      load_setting(PHASES[k]);
      run_gestures(PHASES[k].budget);
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("[button_gesture_classifier_unit] OK");
    end else begin
      $display("[button_gesture_classifier_unit] ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2_000_000;
    $display("[button_gesture_classifier_unit] ERROR");
    $finish;
  end

endmodule
